>>> hdl/kst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kst_pkg
// types, states and constants shared by the spanning tree block
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int unsigned VtxW  = 6;
  localparam int unsigned WgtW  = 32;
  localparam int unsigned CntW  = 7;
  localparam int unsigned RankW = 3;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_RUN = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                   cmd;
    logic [VtxW-1:0]        vertex_a;
    logic [VtxW-1:0]        vertex_b;
    logic signed [WgtW-1:0] weight;
  } cmd_t;

  typedef struct packed {
    logic [VtxW-1:0]        out_vertex_a;
    logic [VtxW-1:0]        out_vertex_b;
    logic signed [WgtW-1:0] out_weight;
    logic                   has_edge;
    logic                   last;
    logic                   dropped;
  } res_t;

  typedef struct packed {
    logic [VtxW-1:0]        a;
    logic [VtxW-1:0]        b;
    logic signed [WgtW-1:0] w;
  } edge_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SKEY,
    ST_SKEY_W,
    ST_SPREV,
    ST_SCMP,
    ST_SPUT,
    ST_INIT,
    ST_ERD,
    ST_EGET,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_F4,
    ST_MERGE,
    ST_MERGE2,
    ST_FLUSH
  } state_e;

endpackage
`default_nettype wire

>>> hdl/kst_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kst_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module kst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> hdl/kruskal_spanning_tree.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kruskal_spanning_tree
// minimum spanning forest over a stored edge list, insertion sort and
// union-find with path halving and union by rank on one shared sequencer
// ----------------------------------------------------------------------------
// add transaction: busy stays low, one add per cycle while the block is idle
// run transaction: the stored edges are insertion sorted by weight, then every
//   union-find entry is reinitialised, then each edge is skipped if out of
//   range, else both roots are found and merged when they differ (a second
//   write on equal ranks), and a final result marked last ends the run
// results leave on res_valid_o for one cycle each; the receiver cannot stall
// reset: edge count, drop flag and sequencer cleared, vertex count set to 64
module kruskal_spanning_tree #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire kst_pkg::cmd_t               cmd_i,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [kst_pkg::CntW-1:0]    cfg_data_i,
  output logic                             res_valid_o,
  output kst_pkg::res_t                    res_o
);

  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned UW  = VW + kst_pkg::RankW;
  localparam int unsigned EW  = $bits(kst_pkg::edge_t);
  localparam logic [CW-1:0] MaxE = CW'(MAX_EDGES);
  localparam logic [VW-1:0] LastV = VW'(MAX_VERTICES - 1);
  localparam logic [kst_pkg::CntW-1:0] MaxV = kst_pkg::CntW'(MAX_VERTICES);

  kst_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, e_q, e_d;
  logic          drop_q, drop_d, phase_q, phase_d, pend_v_q, pend_v_d;
  logic [kst_pkg::CntW-1:0] nv_q, nv_d, n_eff;
  kst_pkg::edge_t key_q, key_d, cur_q, cur_d, pend_q, pend_d;
  logic [VW-1:0] v_q, v_d, p_q, p_d, ra_q, ra_d, rb_q, rb_d;
  logic [kst_pkg::RankW-1:0] rka_q, rka_d, rkb_q, rkb_d;
  logic          res_valid_q, res_valid_d;
  kst_pkg::res_t res_q, res_d;

  logic           e_we;
  logic [EAW-1:0] e_waddr, e_raddr;
  kst_pkg::edge_t e_wdata, e_rdata;
  logic [EW-1:0]  e_rraw;
  logic           u_we;
  logic [VW-1:0]  u_waddr, u_raddr, u_par;
  logic [UW-1:0]  u_wdata, u_rdata;
  logic [kst_pkg::RankW-1:0] u_rank;

  kst_ram #(.Width(EW), .Depth(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rraw)
  );

  kst_ram #(.Width(UW), .Depth(MAX_VERTICES)) u_uf_ram (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (u_waddr),
    .wdata_i (u_wdata),
    .raddr_i (u_raddr),
    .rdata_o (u_rdata)
  );

  assign e_rdata = kst_pkg::edge_t'(e_rraw);
  assign u_par   = u_rdata[VW-1:0];
  assign u_rank  = u_rdata[UW-1:VW];

  always_comb begin
    if (nv_q == '0) begin
      n_eff = kst_pkg::CntW'(1);
    end else if (nv_q > MaxV) begin
      n_eff = MaxV;
    end else begin
      n_eff = nv_q;
    end
  end

  assign busy        = (state_q != kst_pkg::ST_IDLE);
  assign cfg_ready_o = !busy;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    e_d         = e_q;
    drop_d      = drop_q;
    phase_d     = phase_q;
    pend_v_d    = pend_v_q;
    nv_d        = nv_q;
    key_d       = key_q;
    cur_d       = cur_q;
    pend_d      = pend_q;
    v_d         = v_q;
    p_d         = p_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    rka_d       = rka_q;
    rkb_d       = rkb_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    e_we        = 1'b0;
    e_waddr     = cnt_q[EAW-1:0];
    e_wdata     = key_q;
    e_raddr     = i_q[EAW-1:0];
    u_we        = 1'b0;
    u_waddr     = v_q;
    u_wdata     = '0;
    u_raddr     = v_q;

    if (cfg_valid_i && cfg_ready_o) begin
      nv_d = cfg_data_i;
    end

    unique case (state_q)
      kst_pkg::ST_IDLE: begin
        if (start) begin
          if (cmd_i.cmd == kst_pkg::CMD_ADD) begin
            if (cnt_q >= MaxE || {1'b0, cmd_i.vertex_a} >= n_eff ||
                {1'b0, cmd_i.vertex_b} >= n_eff) begin
              drop_d = 1'b1;
            end else begin
              e_we    = 1'b1;
              e_waddr = cnt_q[EAW-1:0];
              e_wdata = '{a: cmd_i.vertex_a, b: cmd_i.vertex_b, w: cmd_i.weight};
              cnt_d   = cnt_q + CW'(1);
            end
          end else begin
            i_d      = CW'(1);
            e_d      = '0;
            v_d      = '0;
            pend_v_d = 1'b0;
            state_d  = (cnt_q > CW'(1)) ? kst_pkg::ST_SKEY : kst_pkg::ST_INIT;
          end
        end
      end
      kst_pkg::ST_SKEY: begin
        e_raddr = i_q[EAW-1:0];
        state_d = kst_pkg::ST_SKEY_W;
      end
      kst_pkg::ST_SKEY_W: begin
        key_d   = e_rdata;
        j_d     = i_q;
        state_d = kst_pkg::ST_SPREV;
      end
      kst_pkg::ST_SPREV: begin
        e_raddr = EAW'(j_q - CW'(1));
        state_d = kst_pkg::ST_SCMP;
      end
      kst_pkg::ST_SCMP: begin
        if (e_rdata.w > key_q.w) begin
          e_we    = 1'b1;
          e_waddr = j_q[EAW-1:0];
          e_wdata = e_rdata;
          j_d     = j_q - CW'(1);
          state_d = (j_q == CW'(1)) ? kst_pkg::ST_SPUT : kst_pkg::ST_SPREV;
        end else begin
          state_d = kst_pkg::ST_SPUT;
        end
      end
      kst_pkg::ST_SPUT: begin
        e_we    = 1'b1;
        e_waddr = j_q[EAW-1:0];
        e_wdata = key_q;
        i_d     = i_q + CW'(1);
        state_d = ((i_q + CW'(1)) < cnt_q) ? kst_pkg::ST_SKEY : kst_pkg::ST_INIT;
      end
      kst_pkg::ST_INIT: begin
        u_we    = 1'b1;
        u_waddr = v_q;
        u_wdata = {{kst_pkg::RankW{1'b0}}, v_q};
        v_d     = v_q + VW'(1);
        if (v_q == LastV) begin
          state_d = kst_pkg::ST_ERD;
        end
      end
      kst_pkg::ST_ERD: begin
        e_raddr = e_q[EAW-1:0];
        state_d = (e_q == cnt_q) ? kst_pkg::ST_FLUSH : kst_pkg::ST_EGET;
      end
      kst_pkg::ST_EGET: begin
        cur_d = e_rdata;
        if ({1'b0, e_rdata.a} >= n_eff || {1'b0, e_rdata.b} >= n_eff) begin
          e_d     = e_q + CW'(1);
          state_d = kst_pkg::ST_ERD;
        end else begin
          v_d     = e_rdata.a[VW-1:0];
          phase_d = 1'b0;
          state_d = kst_pkg::ST_F1;
        end
      end
      kst_pkg::ST_F1: begin
        u_raddr = v_q;
        state_d = kst_pkg::ST_F2;
      end
      kst_pkg::ST_F2: begin
        if (u_par == v_q) begin
          if (!phase_q) begin
            ra_d    = v_q;
            rka_d   = u_rank;
            phase_d = 1'b1;
            v_d     = cur_q.b[VW-1:0];
            state_d = kst_pkg::ST_F1;
          end else begin
            rb_d    = v_q;
            rkb_d   = u_rank;
            state_d = kst_pkg::ST_MERGE;
          end
        end else begin
          p_d     = u_par;
          state_d = kst_pkg::ST_F3;
        end
      end
      kst_pkg::ST_F3: begin
        u_raddr = p_q;
        state_d = kst_pkg::ST_F4;
      end
      kst_pkg::ST_F4: begin
        u_we    = 1'b1;
        u_waddr = v_q;
        u_wdata = {{kst_pkg::RankW{1'b0}}, u_par};
        v_d     = u_par;
        state_d = kst_pkg::ST_F1;
      end
      kst_pkg::ST_MERGE: begin
        e_d = e_q + CW'(1);
        if (ra_q == rb_q) begin
          state_d = kst_pkg::ST_ERD;
        end else begin
          if (pend_v_q) begin
            res_valid_d = 1'b1;
            res_d = '{out_vertex_a: pend_q.a, out_vertex_b: pend_q.b,
                      out_weight: pend_q.w, has_edge: 1'b1, last: 1'b0,
                      dropped: drop_q};
          end
          pend_d   = cur_q;
          pend_v_d = 1'b1;
          u_we     = 1'b1;
          state_d  = kst_pkg::ST_ERD;
          if (rka_q > rkb_q) begin
            u_waddr = rb_q;
            u_wdata = {rkb_q, ra_q};
          end else if (rkb_q > rka_q) begin
            u_waddr = ra_q;
            u_wdata = {rka_q, rb_q};
          end else begin
            u_waddr = rb_q;
            u_wdata = {rkb_q + kst_pkg::RankW'(1), rb_q};
            state_d = kst_pkg::ST_MERGE2;
          end
        end
      end
      kst_pkg::ST_MERGE2: begin
        u_we    = 1'b1;
        u_waddr = ra_q;
        u_wdata = {rka_q, rb_q};
        state_d = kst_pkg::ST_ERD;
      end
      kst_pkg::ST_FLUSH: begin
        res_valid_d = 1'b1;
        if (pend_v_q) begin
          res_d = '{out_vertex_a: pend_q.a, out_vertex_b: pend_q.b,
                    out_weight: pend_q.w, has_edge: 1'b1, last: 1'b1,
                    dropped: drop_q};
        end else begin
          res_d = '{out_vertex_a: '0, out_vertex_b: '0, out_weight: '0,
                    has_edge: 1'b0, last: 1'b1, dropped: drop_q};
        end
        state_d = kst_pkg::ST_IDLE;
      end
      default: begin
        state_d = kst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kst_pkg::ST_IDLE;
      cnt_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      e_q         <= '0;
      drop_q      <= 1'b0;
      phase_q     <= 1'b0;
      pend_v_q    <= 1'b0;
      nv_q        <= kst_pkg::CntW'(64);
      key_q       <= '0;
      cur_q       <= '0;
      pend_q      <= '0;
      v_q         <= '0;
      p_q         <= '0;
      ra_q        <= '0;
      rb_q        <= '0;
      rka_q       <= '0;
      rkb_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      j_q         <= j_d;
      e_q         <= e_d;
      drop_q      <= drop_d;
      phase_q     <= phase_d;
      pend_v_q    <= pend_v_d;
      nv_q        <= nv_d;
      key_q       <= key_d;
      cur_q       <= cur_d;
      pend_q      <= pend_d;
      v_q         <= v_d;
      p_q         <= p_d;
      ra_q        <= ra_d;
      rb_q        <= rb_d;
      rka_q       <= rka_d;
      rkb_q       <= rkb_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

`ifndef SYNTH
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.has_edge) |-> res_o.last)
    else $error("empty result not marked last");

  a_no_adjacent_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("results on adjacent cycles");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxE)
    else $error("edge count beyond store size");

  a_run_ends_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (res_valid_o && res_o.last))
    else $error("run finished without final result");
`endif

endmodule
`default_nettype wire

>>> verif/tb_kruskal_spanning_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kruskal_spanning_tree
// drives add and run commands with random idle bursts, predicts each spanning
// forest edge in a scoreboard and checks every result transaction against it
// ----------------------------------------------------------------------------
module tb_kruskal_spanning_tree;

  localparam int unsigned NV_MAX   = 64;
  localparam int unsigned EDGE_CAP = 256;
  localparam int unsigned LIMIT    = 4000000;

  class forest_scoreboard;
    kst_pkg::edge_t edges[EDGE_CAP];
    int unsigned    edge_cnt;
    bit             drop_seen;
    int unsigned    nv_reg;
    int unsigned    parent[NV_MAX];
    int unsigned    rank_of[NV_MAX];
    kst_pkg::res_t  expected_edges[$];
    int unsigned    mismatches;

    function new();
      edge_cnt   = 0;
      drop_seen  = 0;
      nv_reg     = 64;
      mismatches = 0;
    endfunction

    function int unsigned eff_vertices();
      if (nv_reg < 1) return 1;
      if (nv_reg > NV_MAX) return NV_MAX;
      return nv_reg;
    endfunction

    function int unsigned find_root(int unsigned v);
      while (parent[v] != v) begin
        parent[v] = parent[parent[v]];
        v = parent[v];
      end
      return v;
    endfunction

    function void push_result(int unsigned a, int unsigned b, logic [31:0] w, bit has);
      kst_pkg::res_t r;
      r.out_vertex_a = a[kst_pkg::VtxW-1:0];
      r.out_vertex_b = b[kst_pkg::VtxW-1:0];
      r.out_weight   = w;
      r.has_edge     = has;
      r.last         = 1'b0;
      r.dropped      = drop_seen;
      expected_edges = {expected_edges, r};
    endfunction

    function void note_command(kst_pkg::cmd_t c);
      int unsigned n, j, ra, rb, emitted;
      kst_pkg::edge_t key;
      n = eff_vertices();
      if (c.cmd == kst_pkg::CMD_ADD) begin
        if (edge_cnt >= EDGE_CAP || c.vertex_a >= n || c.vertex_b >= n) begin
          drop_seen = 1;
        end else begin
          edges[edge_cnt] = '{a: c.vertex_a, b: c.vertex_b, w: c.weight};
          edge_cnt++;
        end
        return;
      end
      // stable insertion sort, kept in the store
      for (int unsigned i = 1; i < edge_cnt; i++) begin
        key = edges[i];
        j = i;
        while (j > 0 && $signed(edges[j-1].w) > $signed(key.w)) begin
          edges[j] = edges[j-1];
          j--;
        end
        edges[j] = key;
      end
      for (int unsigned i = 0; i < NV_MAX; i++) begin
        parent[i]  = i;
        rank_of[i] = 0;
      end
      emitted = 0;
      for (int unsigned i = 0; i < edge_cnt; i++) begin
        if (edges[i].a >= n || edges[i].b >= n) continue;
        ra = find_root(edges[i].a);
        rb = find_root(edges[i].b);
        if (ra != rb) begin
          if (emitted < NV_MAX - 1) begin
            push_result(edges[i].a, edges[i].b, edges[i].w, 1'b1);
            emitted++;
          end
          if (rank_of[ra] > rank_of[rb]) begin
            parent[rb] = ra;
          end else if (rank_of[rb] > rank_of[ra]) begin
            parent[ra] = rb;
          end else begin
            rank_of[rb] = (rank_of[rb] + 1) & 7;
            parent[ra]  = rb;
          end
        end
      end
      if (emitted == 0) push_result(0, 0, 32'd0, 1'b0);
      expected_edges[expected_edges.size()-1].last = 1'b1;
    endfunction

    function void check_result(kst_pkg::res_t got);
      kst_pkg::res_t exp_r;
      if (expected_edges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", got);
        return;
      end
      exp_r = expected_edges.pop_front();
      if (got.out_vertex_a !== exp_r.out_vertex_a || got.out_vertex_b !== exp_r.out_vertex_b ||
          got.out_weight !== exp_r.out_weight || got.has_edge !== exp_r.has_edge ||
          got.last !== exp_r.last || got.dropped !== exp_r.dropped) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  kst_pkg::cmd_t cmd_i;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [kst_pkg::CntW-1:0] cfg_data_i;
  logic          res_valid_o;
  kst_pkg::res_t res_o;

  forest_scoreboard sb = new();
  int unsigned cycle_cnt;
  bit          idle_on;

  kruskal_spanning_tree u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_command(cmd_i);
      if (res_valid_o) sb.check_result(res_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("tb_kruskal_spanning_tree failed");
      $finish;
    end
  end

  task automatic send_cmd(kst_pkg::cmd_t c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    start = 1'b1;
    cmd_i = c;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic add_edge(int unsigned a, int unsigned b, logic [31:0] w);
    kst_pkg::cmd_t c;
    c.cmd      = kst_pkg::CMD_ADD;
    c.vertex_a = a[kst_pkg::VtxW-1:0];
    c.vertex_b = b[kst_pkg::VtxW-1:0];
    c.weight   = w;
    send_cmd(c);
  endtask

  task automatic run_forest();
    kst_pkg::cmd_t c;
    logic [31:0] ra, rb;
    ra         = $urandom();
    rb         = $urandom();
    c.cmd      = kst_pkg::CMD_RUN;
    c.vertex_a = ra[kst_pkg::VtxW-1:0];
    c.vertex_b = rb[kst_pkg::VtxW-1:0];
    c.weight   = $urandom();
    send_cmd(c);
  endtask

  task automatic drain();
    start = 1'b0;
    while (sb.expected_edges.size() != 0 || busy) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_vertices(int unsigned v);
    drain();
    cfg_data_i  = v[kst_pkg::CntW-1:0];
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.nv_reg = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_item();
    int unsigned n, a, b;
    logic [31:0] w;
    n = sb.eff_vertices();
    if ($urandom_range(0, 7) == 0) begin
      run_forest();
    end else begin
      if ($urandom_range(0, 6) == 0) begin
        a = $urandom_range(0, 63);
        b = $urandom_range(0, 63);
      end else begin
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
      end
      w = ($urandom_range(0, 1) == 0) ? 32'($signed($urandom_range(0, 16)) - 8) : $urandom();
      add_edge(a, b, w);
    end
  endtask

  initial begin
    int unsigned nv_pick[6];
    cycle_cnt   = 0;
    idle_on     = 1'b1;
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty store, then extremes, ties and a self loop
    run_forest();
    add_edge(0, 1, 32'h7fffffff);
    add_edge(1, 2, 32'h80000000);
    add_edge(2, 3, 32'd0);
    add_edge(3, 3, 32'hfffffffb);
    add_edge(62, 63, 32'd5);
    add_edge(0, 63, 32'd5);
    add_edge(2, 0, 32'hffffffff);
    add_edge(1, 3, 32'hffffffff);
    run_forest();
    write_vertices(0);
    add_edge(0, 0, 32'd7);
    add_edge(1, 0, 32'd7);
    run_forest();
    write_vertices(127);
    run_forest();
    write_vertices(4);
    add_edge(63, 0, 32'd1);
    run_forest();
    write_vertices(64);

    nv_pick = '{1, 2, 64, 0, 127, 64};
    for (int i = 0; i < 140; i++) begin
      if (i % 25 == 24) begin
        if ($urandom_range(0, 1) == 0) write_vertices(nv_pick[$urandom_range(0, 5)]);
        else write_vertices($urandom_range(1, 64));
      end
      if (i == 60) drain();
      if (i == 110) begin
        write_vertices(64);
        idle_on = 1'b0;
      end
      random_item();
    end

    run_forest();
    start = 1'b0;

    while (sb.expected_edges.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.expected_edges.size() == 0) begin
      $display("tb_kruskal_spanning_tree passed");
    end else begin
      $display("tb_kruskal_spanning_tree failed");
    end
    $finish;
  end

endmodule
